@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file sipq_checker.sv
// depends on nothing; every macro takes its own clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/sipq_pkg.sv @@
// shared types and constants of the sorted-insert priority queue
// depends on nothing
`default_nettype none

package sipq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int VALUE_W = 32;
    localparam int LEVEL_W = 16;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL_REFUSED  = 2'd1;
    localparam logic [1:0] ST_EMPTY_REFUSED = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEVEL_W-1:0] level;
    } entry_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } sipq_cmd_t;

endpackage

`default_nettype wire

@@ rtl/sipq_ctrl.sv @@
// controller of the priority queue: capture and execute sequencing, result valid
// depends on sipq_pkg
`default_nettype none

module sipq_ctrl
    import sipq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    output logic           result_valid,
    input  wire logic      result_stall,
    output sipq_cmd_t      cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   out_free;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    // output register can take a new result this cycle
    assign out_free     = !result_valid_reg || !result_stall;

    always_comb
    begin
        cmd.capture       = item_valid && (state_reg == S_IDLE);
        cmd.execute       = 1'b0;
        state_next        = state_reg;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.execute       = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sipq_datapath.sv @@
// datapath of the priority queue: input beat latch, sorted cell row, count, result registers
// depends on sipq_pkg
`default_nettype none

module sipq_datapath
    import sipq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sipq_cmd_t                 cmd,
    input  wire logic [1:0]                kind,
    input  wire logic signed [VALUE_W-1:0] new_value,
    input  wire logic [LEVEL_W-1:0]        new_level,
    output logic [1:0]                     status,
    output logic signed [VALUE_W-1:0]      taken_value,
    output logic [LEVEL_W-1:0]             taken_level,
    output logic signed [VALUE_W-1:0]      head_value,
    output logic [LEVEL_W-1:0]             head_level,
    output logic signed [VALUE_W-1:0]      rear_value,
    output logic [CNT_W-1:0]               entry_count,
    output logic                           is_empty,
    output logic                           is_full
);

    // latched input beat
    logic [1:0]         kind_reg;
    entry_t             new_reg;

    // sorted cells, head at index 0
    entry_t             cells_reg [DEPTH];
    entry_t             cells_next [DEPTH];
    entry_t             cells_dn [DEPTH];
    entry_t             cells_up [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [DEPTH-1:0]   gt;
    logic [DEPTH-1:0]   gt_prev;
    logic               cur_empty;
    logic               cur_full;
    logic [1:0]         status_next;
    entry_t             taken_next;
    entry_t             head_next;
    logic [VALUE_W-1:0] rear_next;
    logic [IDX_W-1:0]   rear_idx;

    // result registers
    logic [1:0]         status_reg;
    entry_t             taken_reg;
    entry_t             head_reg;
    logic [VALUE_W-1:0] rear_reg;
    logic [CNT_W-1:0]   out_count_reg;

    assign cur_empty = (count_reg == '0);
    assign cur_full  = (count_reg == CNT_W'(DEPTH));

    // each cell compares its level with the new one; empty cells count as larger
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CNT_W'(i) >= count_reg) || (cells_reg[i].level > new_reg.level);
        end
        gt_prev[0]  = 1'b0;
        cells_dn[0] = cells_reg[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            gt_prev[i]  = gt[i-1];
            cells_dn[i] = cells_reg[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            cells_up[i] = cells_reg[i+1];
        end
        cells_up[DEPTH-1] = cells_reg[DEPTH-1];
    end

    always_comb
    begin
        cells_next  = cells_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        taken_next  = '0;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (cur_full)
                begin
                    status_next = ST_FULL_REFUSED;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (gt[i] && !gt_prev[i])
                        begin
                            cells_next[i] = new_reg;
                        end
                        else if (gt_prev[i])
                        begin
                            cells_next[i] = cells_dn[i];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (cur_empty)
                begin
                    status_next = ST_EMPTY_REFUSED;
                end
                else
                begin
                    taken_next = cells_reg[0];
                    cells_next = cells_up;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                cells_next = cells_reg;
            end
        endcase

        rear_idx = IDX_W'(count_next - 1'b1);
        if (count_next == '0)
        begin
            head_next = '0;
            rear_next = '0;
        end
        else
        begin
            head_next = cells_next[0];
            rear_next = cells_next[rear_idx].value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg      <= kind;
            new_reg.value <= VALUE_W'(new_value);
            new_reg.level <= new_level;
        end
        if (cmd.execute)
        begin
            cells_reg     <= cells_next;
            status_reg    <= status_next;
            taken_reg     <= taken_next;
            head_reg      <= head_next;
            rear_reg      <= rear_next;
            out_count_reg <= count_next;
        end
    end

    assign status      = status_reg;
    assign taken_value = signed'(taken_reg.value);
    assign taken_level = taken_reg.level;
    assign head_value  = signed'(head_reg.value);
    assign head_level  = head_reg.level;
    assign rear_value  = signed'(rear_reg);
    assign entry_count = out_count_reg;
    assign is_empty    = (out_count_reg == '0);
    assign is_full     = (out_count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

@@ rtl/sorted_insert_priority_queue.sv @@
// ascending priority queue of DEPTH entries kept sorted in a row of cells
// flow: the item beat is captured, then all cells compare and shift in parallel once
// the result register is free; the result beat is valid from the edge of that shift
// a new item is taken only after the previous one has executed (capture, then one parallel
// compare-and-shift of all cells); held longer only while the previous result is stalled
// reset: rst_n clears the count, the sequencer and result valid; cell contents stay
// undefined until written
`default_nettype none

module sorted_insert_priority_queue
    import sipq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // item channel
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire logic [1:0]                kind,
    input  wire logic signed [VALUE_W-1:0] new_value,
    input  wire logic [LEVEL_W-1:0]        new_level,
    // result channel
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output logic [1:0]                     status,
    output logic signed [VALUE_W-1:0]      taken_value,
    output logic [LEVEL_W-1:0]             taken_level,
    output logic signed [VALUE_W-1:0]      head_value,
    output logic [LEVEL_W-1:0]             head_level,
    output logic signed [VALUE_W-1:0]      rear_value,
    output logic [CNT_W-1:0]               entry_count,
    output logic                           is_empty,
    output logic                           is_full
);

    // capture / execute commands from the sequencer to the cell row
    sipq_cmd_t cmd;

    // sequencer: takes one item beat, then fires the shift once the
    // result register is free (empty or being drained this cycle)
    sipq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    // cell row: every cell compares its level with the new one in parallel;
    // on insert the cells from the insertion point on shift right, on remove all shift left;
    // equal levels stay ahead of the new entry so the oldest is served first
    sipq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .new_value   (new_value),
        .new_level   (new_level),
        .status      (status),
        .taken_value (taken_value),
        .taken_level (taken_level),
        .head_value  (head_value),
        .head_level  (head_level),
        .rear_value  (rear_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule

`default_nettype wire

@@ rtl/sipq_checker.sv @@
// port-level checks of the priority queue, bound to the top level
// depends on sipq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sipq_checker
    import sipq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      result_valid,
    input  wire logic                      result_stall,
    input  wire logic [1:0]                status,
    input  wire logic signed [VALUE_W-1:0] taken_value,
    input  wire logic [LEVEL_W-1:0]        taken_level,
    input  wire logic signed [VALUE_W-1:0] head_value,
    input  wire logic [LEVEL_W-1:0]        head_level,
    input  wire logic signed [VALUE_W-1:0] rear_value,
    input  wire logic [CNT_W-1:0]          entry_count,
    input  wire logic                      is_empty,
    input  wire logic                      is_full
);

    `ASSERT_IMPLIES(a_empty_flags, clk, rst_n, result_valid && is_empty, entry_count == '0 && !is_full)
    `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, result_valid && is_empty, head_value == '0 && head_level == '0 && rear_value == '0)
    `ASSERT_IMPLIES(a_refused_remove, clk, rst_n, result_valid && status == ST_EMPTY_REFUSED, is_empty && taken_value == '0 && taken_level == '0)
    `ASSERT_IMPLIES(a_refused_insert, clk, rst_n, result_valid && status == ST_FULL_REFUSED, is_full && entry_count == CNT_W'(DEPTH))
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(status) && $stable(entry_count))

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .taken_value  (taken_value),
    .taken_level  (taken_level),
    .head_value   (head_value),
    .head_level   (head_level),
    .rear_value   (rear_value),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .is_full      (is_full)
);

`default_nettype wire
